>>> src/aki_pkg.sv
// ---------------------------------------------------------------------------
// aki_pkg
// Shared types, codes and reset constants of the adaptive keepalive block.
// ---------------------------------------------------------------------------
package aki_pkg;

  // Default widths of the interval values and the run counters.
  localparam int unsigned INTERVAL_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF    = 8;

  // Fixed widths of the threshold registers, the register index and the result interval.
  localparam int unsigned THRESH_BITS = 8;
  localparam int unsigned INDEX_BITS  = 3;
  localparam int unsigned OUT_BITS    = 32;

  // Reset values of the configuration registers.
  localparam logic [63:0] MIN_INTERVAL_RST   = 64'd240000;
  localparam logic [63:0] MAX_INTERVAL_RST   = 64'd600000;
  localparam logic [63:0] STEP_SIZE_RST      = 64'd60000;
  localparam logic [63:0] CEILING_MARGIN_RST = 64'd60000;
  localparam logic [THRESH_BITS-1:0] SUCCESSES_TO_RAISE_RST = 8'd3;
  localparam logic [THRESH_BITS-1:0] FAILURES_TO_LOWER_RST  = 8'd2;
  localparam logic [THRESH_BITS-1:0] PROBE_SUCCESSES_RST    = 8'd3;

  // Event codes.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_END    = 2'd1,
    CMD_RESP   = 2'd2,
    CMD_EXPIRY = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [INDEX_BITS-1:0] {
    REG_MIN_INTERVAL       = 3'd0,
    REG_MAX_INTERVAL       = 3'd1,
    REG_STEP_SIZE          = 3'd2,
    REG_CEILING_MARGIN     = 3'd3,
    REG_SUCCESSES_TO_RAISE = 3'd4,
    REG_FAILURES_TO_LOWER  = 3'd5,
    REG_PROBE_SUCCESSES    = 3'd6
  } reg_idx_t;

  // Status bits of one result.
  typedef struct packed {
    logic send_heartbeat;
    logic timed_out;
    logic is_stable;
  } result_flags_t;

  // Single-bit session state.
  typedef struct packed {
    logic stable_flag;
    logic awaiting_reply;
  } sess_flags_t;

endpackage

>>> src/aki_step.sv
// ---------------------------------------------------------------------------
// aki_step
// Next-state and result logic for one keepalive event.
// ---------------------------------------------------------------------------
module aki_step #(
  parameter int unsigned INTERVAL_BITS = aki_pkg::INTERVAL_BITS_DEF,
  parameter int unsigned COUNT_BITS    = aki_pkg::COUNT_BITS_DEF
) (
  input  aki_pkg::cmd_t                  cmd,
  input  logic                           foreground,
  // Configuration.
  input  logic [INTERVAL_BITS-1:0]       min_interval,
  input  logic [INTERVAL_BITS-1:0]       max_interval,
  input  logic [INTERVAL_BITS-1:0]       step_size,
  input  logic [INTERVAL_BITS-1:0]       ceiling_margin,
  input  logic [aki_pkg::THRESH_BITS-1:0] successes_to_raise,
  input  logic [aki_pkg::THRESH_BITS-1:0] failures_to_lower,
  input  logic [aki_pkg::THRESH_BITS-1:0] probe_successes,
  // Present state.
  input  logic [INTERVAL_BITS-1:0]       current_interval,
  input  logic [COUNT_BITS-1:0]          success_run,
  input  logic [COUNT_BITS-1:0]          failure_run,
  input  logic [COUNT_BITS-1:0]          probe_seen,
  input  aki_pkg::sess_flags_t           flags,
  // Next state.
  output logic [INTERVAL_BITS-1:0]       current_interval_next,
  output logic [COUNT_BITS-1:0]          success_run_next,
  output logic [COUNT_BITS-1:0]          failure_run_next,
  output logic [COUNT_BITS-1:0]          probe_seen_next,
  output aki_pkg::sess_flags_t           flags_next,
  // Result.
  output logic [aki_pkg::OUT_BITS-1:0]   next_interval,
  output aki_pkg::result_flags_t         result
);

  // Counters and thresholds are compared at a common width.
  localparam int unsigned CMP_BITS =
    (COUNT_BITS > aki_pkg::THRESH_BITS) ? COUNT_BITS : aki_pkg::THRESH_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Ceiling where the interval is held as stable; zero if the margin is too large.
  logic [INTERVAL_BITS-1:0] ceiling;
  assign ceiling = (max_interval > ceiling_margin) ? (max_interval - ceiling_margin)
                                                  : '0;

  // Success adjustment.
  logic [INTERVAL_BITS-1:0] suc_interval;
  logic [COUNT_BITS-1:0]    suc_run;
  logic                     suc_stable;
  logic [COUNT_BITS-1:0]    suc_count;
  logic [INTERVAL_BITS:0]   raise_sum;

  assign suc_count = (success_run == CNT_MAX) ? CNT_MAX : success_run + 1'b1;
  assign raise_sum = {1'b0, current_interval} + {1'b0, step_size};

  always_comb begin
    suc_interval = current_interval;
    suc_run      = suc_count;
    suc_stable   = flags.stable_flag;
    if (current_interval >= ceiling) begin
      suc_interval = ceiling;
      suc_stable   = 1'b1;
    end else if (CMP_BITS'(suc_count) >= CMP_BITS'(successes_to_raise)) begin
      // Step up, clamped to the maximum on overflow or when reaching it.
      if (raise_sum[INTERVAL_BITS] ||
          (raise_sum[INTERVAL_BITS-1:0] >= max_interval)) begin
        suc_interval = max_interval;
      end else begin
        suc_interval = raise_sum[INTERVAL_BITS-1:0];
      end
      suc_run = '0;
    end
  end

  // Failure adjustment.
  logic [INTERVAL_BITS-1:0] fail_interval;
  logic [COUNT_BITS-1:0]    fail_run;
  logic                     fail_stable;
  logic [COUNT_BITS-1:0]    fail_count;
  logic [INTERVAL_BITS-1:0] lower_diff;

  assign fail_count = (failure_run == CNT_MAX) ? CNT_MAX : failure_run + 1'b1;
  assign lower_diff = current_interval - step_size;

  always_comb begin
    fail_interval = current_interval;
    fail_run      = fail_count;
    fail_stable   = flags.stable_flag;
    if (current_interval <= min_interval) begin
      fail_interval = min_interval;
    end else if (CMP_BITS'(fail_count) >= CMP_BITS'(failures_to_lower)) begin
      if (flags.stable_flag) begin
        // A stable interval that fails drops straight to the minimum.
        fail_interval = min_interval;
        fail_stable   = 1'b0;
      end else begin
        // Step down, never below the minimum.
        if ((current_interval > step_size) && (lower_diff > min_interval)) begin
          fail_interval = lower_diff;
        end else begin
          fail_interval = min_interval;
        end
        fail_stable = 1'b1;
      end
      fail_run = '0;
    end
  end

  // Event decode.
  logic                     ok;
  logic [COUNT_BITS-1:0]    probe_inc;
  logic [INTERVAL_BITS-1:0] result_interval;

  assign ok        = !flags.awaiting_reply;
  assign probe_inc = (probe_seen == CNT_MAX) ? CNT_MAX : probe_seen + 1'b1;

  always_comb begin
    current_interval_next = current_interval;
    success_run_next      = success_run;
    failure_run_next      = failure_run;
    probe_seen_next       = probe_seen;
    flags_next            = flags;
    result_interval       = '0;
    result.send_heartbeat = 1'b0;
    result.timed_out      = 1'b0;
    unique case (cmd)
      aki_pkg::CMD_START: begin
        probe_seen_next           = '0;
        flags_next.awaiting_reply = 1'b1;
        result_interval           = current_interval;
      end
      aki_pkg::CMD_END: begin
        if (flags.awaiting_reply) begin
          current_interval_next  = fail_interval;
          failure_run_next       = fail_run;
          flags_next.stable_flag = fail_stable;
        end
        flags_next.awaiting_reply = 1'b0;
        success_run_next          = '0;
        probe_seen_next           = '0;
      end
      aki_pkg::CMD_RESP: begin
        flags_next.awaiting_reply = 1'b0;
      end
      aki_pkg::CMD_EXPIRY: begin
        result.send_heartbeat = ok;
        result.timed_out      = !ok;
        if (foreground) begin
          result_interval = ok ? min_interval : '0;
        end else begin
          if (ok) begin
            probe_seen_next = probe_inc;
          end
          // Adjustments start only once the probe phase has passed.
          if (CMP_BITS'(probe_seen_next) > CMP_BITS'(probe_successes)) begin
            if (ok) begin
              current_interval_next  = suc_interval;
              success_run_next       = suc_run;
              failure_run_next       = '0;
              flags_next.stable_flag = suc_stable;
            end else begin
              current_interval_next  = fail_interval;
              success_run_next       = '0;
              failure_run_next       = fail_run;
              flags_next.stable_flag = fail_stable;
            end
          end
          flags_next.awaiting_reply = ok;
          result_interval           = ok ? current_interval_next : '0;
        end
      end
      default: begin
      end
    endcase
    result.is_stable = flags_next.stable_flag;
  end

  // The result interval is shown at its fixed port width.
  logic [63:0] result_wide;
  assign result_wide      = 64'(result_interval);
  assign next_interval    = result_wide[aki_pkg::OUT_BITS-1:0];

endmodule

>>> src/adaptive_keepalive_interval.sv
// ---------------------------------------------------------------------------
// adaptive_keepalive_interval
// Keepalive interval adaptation from heartbeat outcomes.
// ---------------------------------------------------------------------------
// Usage:
//   Events (cmd, foreground) enter on the in_valid/in_ready channel; each
//   event yields exactly one result (next_interval, send_heartbeat,
//   timed_out, is_stable_now) on the out_valid/out_ready channel.
//   Configuration registers are written over cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high and unknown indexes
//   are dropped. Write registers only while no event is in flight.
// Timing:
//   An event is registered in the input register on acceptance and is
//   evaluated against the session state there; its result is registered
//   in the result register once that register is free. One event per cycle
//   is sustained while out_ready is high; the session state is a single
//   register set updated once per event.
// Reset:
//   rst restores the default configuration, sets the interval to the
//   default minimum and clears all counters, flags and pending transactions.
// Backpressure:
//   While out_ready is low the result holds; one more event waits in the
//   input register, after which in_ready drops.
// ---------------------------------------------------------------------------
module adaptive_keepalive_interval #(
  parameter int unsigned INTERVAL_BITS = aki_pkg::INTERVAL_BITS_DEF,
  parameter int unsigned COUNT_BITS    = aki_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aki_pkg::INDEX_BITS-1:0]   cfg_index,
  input  logic [INTERVAL_BITS-1:0]         cfg_data,
  // Event channel.
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic                             foreground,
  // Result channel.
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [aki_pkg::OUT_BITS-1:0]     next_interval,
  output logic                             send_heartbeat,
  output logic                             timed_out,
  output logic                             is_stable_now
);

  // Configuration registers.
  logic [INTERVAL_BITS-1:0]          min_interval;
  logic [INTERVAL_BITS-1:0]          max_interval;
  logic [INTERVAL_BITS-1:0]          step_size;
  logic [INTERVAL_BITS-1:0]          ceiling_margin;
  logic [aki_pkg::THRESH_BITS-1:0]   successes_to_raise;
  logic [aki_pkg::THRESH_BITS-1:0]   failures_to_lower;
  logic [aki_pkg::THRESH_BITS-1:0]   probe_successes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval       <= INTERVAL_BITS'(aki_pkg::MIN_INTERVAL_RST);
      max_interval       <= INTERVAL_BITS'(aki_pkg::MAX_INTERVAL_RST);
      step_size          <= INTERVAL_BITS'(aki_pkg::STEP_SIZE_RST);
      ceiling_margin     <= INTERVAL_BITS'(aki_pkg::CEILING_MARGIN_RST);
      successes_to_raise <= aki_pkg::SUCCESSES_TO_RAISE_RST;
      failures_to_lower  <= aki_pkg::FAILURES_TO_LOWER_RST;
      probe_successes    <= aki_pkg::PROBE_SUCCESSES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aki_pkg::REG_MIN_INTERVAL:       min_interval       <= cfg_data;
        aki_pkg::REG_MAX_INTERVAL:       max_interval       <= cfg_data;
        aki_pkg::REG_STEP_SIZE:          step_size          <= cfg_data;
        aki_pkg::REG_CEILING_MARGIN:     ceiling_margin     <= cfg_data;
        aki_pkg::REG_SUCCESSES_TO_RAISE:
          successes_to_raise <= cfg_data[aki_pkg::THRESH_BITS-1:0];
        aki_pkg::REG_FAILURES_TO_LOWER:
          failures_to_lower  <= cfg_data[aki_pkg::THRESH_BITS-1:0];
        aki_pkg::REG_PROBE_SUCCESSES:
          probe_successes    <= cfg_data[aki_pkg::THRESH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control: the evaluate stage advances when the result register is free.
  logic in_full;
  logic advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_full || advance;

  // Input register.
  aki_pkg::cmd_t in_cmd;
  logic          in_fg;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd <= aki_pkg::cmd_t'(cmd);
      in_fg  <= foreground;
    end
  end

  // Session state.
  logic [INTERVAL_BITS-1:0] current_interval;
  logic [COUNT_BITS-1:0]    success_run;
  logic [COUNT_BITS-1:0]    failure_run;
  logic [COUNT_BITS-1:0]    probe_seen;
  aki_pkg::sess_flags_t     flags;

  logic [INTERVAL_BITS-1:0] current_interval_next;
  logic [COUNT_BITS-1:0]    success_run_next;
  logic [COUNT_BITS-1:0]    failure_run_next;
  logic [COUNT_BITS-1:0]    probe_seen_next;
  aki_pkg::sess_flags_t     flags_next;

  logic [aki_pkg::OUT_BITS-1:0] step_interval;
  aki_pkg::result_flags_t       step_result;

  aki_step #(
    .INTERVAL_BITS (INTERVAL_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_step (
    .cmd                   (in_cmd),
    .foreground            (in_fg),
    .min_interval          (min_interval),
    .max_interval          (max_interval),
    .step_size             (step_size),
    .ceiling_margin        (ceiling_margin),
    .successes_to_raise    (successes_to_raise),
    .failures_to_lower     (failures_to_lower),
    .probe_successes       (probe_successes),
    .current_interval      (current_interval),
    .success_run           (success_run),
    .failure_run           (failure_run),
    .probe_seen            (probe_seen),
    .flags                 (flags),
    .current_interval_next (current_interval_next),
    .success_run_next      (success_run_next),
    .failure_run_next      (failure_run_next),
    .probe_seen_next       (probe_seen_next),
    .flags_next            (flags_next),
    .next_interval         (step_interval),
    .result                (step_result)
  );

  // State update, once per evaluated event.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_interval <= INTERVAL_BITS'(aki_pkg::MIN_INTERVAL_RST);
      success_run      <= '0;
      failure_run      <= '0;
      probe_seen       <= '0;
      flags            <= '0;
    end else if (in_full && advance) begin
      current_interval <= current_interval_next;
      success_run      <= success_run_next;
      failure_run      <= failure_run_next;
      probe_seen       <= probe_seen_next;
      flags            <= flags_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_full && advance) begin
      next_interval  <= step_interval;
      send_heartbeat <= step_result.send_heartbeat;
      timed_out      <= step_result.timed_out;
      is_stable_now  <= step_result.is_stable;
    end
  end

  // Checks on the block's own logic.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_full && out_valid && !out_ready))
    else $error("event channel stalled while a stage was free");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && timed_out) |-> (next_interval == '0 && !send_heartbeat))
    else $error("timeout result carries an interval or a heartbeat");

  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> $past(in_full))
    else $error("result appeared without an event in the input register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_full))
    else $error("pipeline not empty after reset");

endmodule

>>> tb/sv/adaptive_keepalive_interval_test.sv
// ---------------------------------------------------------------------------
// adaptive_keepalive_interval_test
// Self-checking testbench for the adaptive keepalive interval block. A short
// table of directed events runs first under the reset configuration. It is
// followed by phases of random heartbeat sessions, each under its own
// register setting. Every result is checked against an in-bench model of the
// interval adaptation or the fixed result of a typed row. Both channels idle
// at random, and the receiver holds off once for a long stretch.
// ---------------------------------------------------------------------------
module adaptive_keepalive_interval_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IB          = aki_pkg::INTERVAL_BITS_DEF;
  localparam int unsigned CB          = aki_pkg::COUNT_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 115;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned LONG_HOLD   = 150;
  localparam int unsigned MAX_REPORTS = 10;
  // Index outside the register map; a write to it must change nothing.
  localparam logic [aki_pkg::INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef logic [IB-1:0]                   ival_t;
  typedef logic [CB-1:0]                   cnt_t;
  typedef logic [aki_pkg::THRESH_BITS-1:0] thr_t;

  typedef struct packed {
    logic [aki_pkg::OUT_BITS-1:0] next;
    logic                         send;
    logic                         tmo;
    logic                         stab;
  } ka_result_t;

  // One event as offered to the block; typed rows carry a fixed result.
  typedef struct packed {
    aki_pkg::cmd_t op;
    logic          fg;
    logic          typed;
    ka_result_t    want;
  } ka_event_t;

  // Directed events under the reset configuration.
  localparam int DIR_ROWS = 20;
  localparam ka_event_t DIRECTED_EVENTS [DIR_ROWS] = '{
    // Foreground expiry with no reply pending returns the minimum.
    '{aki_pkg::CMD_EXPIRY, 1'b1, 1'b1, '{32'd240000, 1'b1, 1'b0, 1'b0}},
    // Start arms the timer with the current interval.
    '{aki_pkg::CMD_START,  1'b0, 1'b1, '{32'd240000, 1'b0, 1'b0, 1'b0}},
    // Foreground expiry while a reply is pending is a timeout.
    '{aki_pkg::CMD_EXPIRY, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b0}},
    '{aki_pkg::CMD_RESP,   1'b1, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b0}},
    // Probe phase, then a run of successes that raises the interval.
    '{aki_pkg::CMD_EXPIRY, 1'b0, 1'b0, '0},
    '{aki_pkg::CMD_RESP,   1'b0, 1'b0, '0},
    '{aki_pkg::CMD_EXPIRY, 1'b0, 1'b0, '0},
    '{aki_pkg::CMD_RESP,   1'b0, 1'b0, '0},
    '{aki_pkg::CMD_EXPIRY, 1'b0, 1'b0, '0},
    '{aki_pkg::CMD_RESP,   1'b0, 1'b0, '0},
    '{aki_pkg::CMD_EXPIRY, 1'b0, 1'b0, '0},
    '{aki_pkg::CMD_RESP,   1'b0, 1'b0, '0},
    '{aki_pkg::CMD_EXPIRY, 1'b0, 1'b0, '0},
    '{aki_pkg::CMD_RESP,   1'b0, 1'b0, '0},
    '{aki_pkg::CMD_EXPIRY, 1'b0, 1'b0, '0},
    // Background failure, then a session that ends with a reply pending.
    '{aki_pkg::CMD_EXPIRY, 1'b0, 1'b0, '0},
    '{aki_pkg::CMD_END,    1'b0, 1'b0, '0},
    '{aki_pkg::CMD_START,  1'b1, 1'b0, '0},
    '{aki_pkg::CMD_END,    1'b1, 1'b0, '0},
    '{aki_pkg::CMD_RESP,   1'b1, 1'b0, '0}
  };

  logic                           clk;
  logic                           rst        = 1'b1;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [aki_pkg::INDEX_BITS-1:0] cfg_index  = '0;
  ival_t                          cfg_data   = '0;
  logic                           in_valid   = 1'b0;
  logic                           in_ready;
  logic [1:0]                     cmd        = '0;
  logic                           foreground = 1'b0;
  logic                           out_valid;
  logic                           out_ready  = 1'b0;
  logic [aki_pkg::OUT_BITS-1:0]   next_interval;
  logic                           send_heartbeat;
  logic                           timed_out;
  logic                           is_stable_now;

  // Event currently on the input channel, kept for the acceptance monitor.
  ka_event_t offer = '0;

  // Register mirror used by the interval model.
  ival_t min_iv      = aki_pkg::MIN_INTERVAL_RST[IB-1:0];
  ival_t max_iv      = aki_pkg::MAX_INTERVAL_RST[IB-1:0];
  ival_t step_iv     = aki_pkg::STEP_SIZE_RST[IB-1:0];
  ival_t margin_iv   = aki_pkg::CEILING_MARGIN_RST[IB-1:0];
  thr_t  raise_after = aki_pkg::SUCCESSES_TO_RAISE_RST;
  thr_t  lower_after = aki_pkg::FAILURES_TO_LOWER_RST;
  thr_t  probe_after = aki_pkg::PROBE_SUCCESSES_RST;

  // Session state of the interval model.
  ival_t sess_interval = aki_pkg::MIN_INTERVAL_RST[IB-1:0];
  cnt_t  sess_succ_run = '0;
  cnt_t  sess_fail_run = '0;
  cnt_t  sess_probe    = '0;
  logic  sess_stable   = 1'b0;
  logic  sess_awaiting = 1'b0;

  ka_result_t  pending_results [$];
  ka_event_t   stim_q [$];
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned cycle_count   = 0;

  adaptive_keepalive_interval dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .foreground     (foreground),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .next_interval  (next_interval),
    .send_heartbeat (send_heartbeat),
    .timed_out      (timed_out),
    .is_stable_now  (is_stable_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run counters stop at all ones.
  function automatic cnt_t sat_inc(cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // A failed heartbeat: lowers the interval after enough failures in a row.
  function automatic void register_failure();
    sess_succ_run = '0;
    sess_fail_run = sat_inc(sess_fail_run);
    if (sess_interval <= min_iv) begin
      sess_interval = min_iv;
    end else if (sess_fail_run >= lower_after) begin
      if (sess_stable) begin
        sess_interval = min_iv;
        sess_stable   = 1'b0;
      end else begin
        if (sess_interval > step_iv && sess_interval - step_iv > min_iv)
          sess_interval = sess_interval - step_iv;
        else
          sess_interval = min_iv;
        sess_stable = 1'b1;
      end
      sess_succ_run = '0;
      sess_fail_run = '0;
    end
  endfunction

  // Applies one event to the session state and returns its result.
  function automatic ka_result_t keepalive_predict(aki_pkg::cmd_t op, logic fg);
    ka_result_t    res;
    logic          ok;
    ival_t         ceiling;
    logic [IB:0]   sum;
    res = '0;
    case (op)
      aki_pkg::CMD_START: begin
        sess_probe    = '0;
        sess_awaiting = 1'b1;
        res.next      = sess_interval;
      end
      aki_pkg::CMD_END: begin
        if (sess_awaiting)
          register_failure();
        sess_awaiting = 1'b0;
        sess_succ_run = '0;
        sess_probe    = '0;
      end
      aki_pkg::CMD_RESP: begin
        sess_awaiting = 1'b0;
      end
      default: begin
        ok = !sess_awaiting;
        if (fg) begin
          res.next = ok ? min_iv : '0;
        end else begin
          if (ok)
            sess_probe = sat_inc(sess_probe);
          if (sess_probe > probe_after) begin
            if (ok) begin
              // Success: hold at the ceiling, or step up after a full run.
              ceiling       = (max_iv > margin_iv) ? max_iv - margin_iv : '0;
              sess_fail_run = '0;
              sess_succ_run = sat_inc(sess_succ_run);
              if (sess_interval >= ceiling) begin
                sess_interval = ceiling;
                sess_stable   = 1'b1;
              end else if (sess_succ_run >= raise_after) begin
                sum = {1'b0, sess_interval} + {1'b0, step_iv};
                sess_interval = (sum[IB] || sum >= {1'b0, max_iv}) ? max_iv : sum[IB-1:0];
                sess_succ_run = '0;
              end
            end else begin
              register_failure();
            end
          end
          sess_awaiting = ok;
          res.next      = ok ? sess_interval : '0;
        end
        res.send = ok;
        res.tmo  = !ok;
      end
    endcase
    res.stab = sess_stable;
    return res;
  endfunction

  function automatic ka_event_t mk_event(aki_pkg::cmd_t op, logic fg);
    return '{op, fg, 1'b0, '0};
  endfunction

  // Appends one heartbeat session, sometimes cut short or mixed with noise.
  task automatic add_session();
    int unsigned beats;
    int unsigned succ_pct;
    int unsigned pick;
    beats = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
    case ($urandom_range(2))
      0:       succ_pct = 90;
      1:       succ_pct = 50;
      default: succ_pct = 10;
    endcase
    stim_q.push_back(mk_event(aki_pkg::CMD_START, 1'($urandom_range(1))));
    repeat (beats) begin
      pick = $urandom_range(99);
      if (pick < 7) begin
        stim_q.push_back(mk_event(aki_pkg::cmd_t'($urandom_range(3)),
                                  1'($urandom_range(1))));
      end else if (pick < 15) begin
        stim_q.push_back(mk_event(aki_pkg::CMD_EXPIRY, 1'b1));
      end else if ($urandom_range(99) < succ_pct) begin
        stim_q.push_back(mk_event(aki_pkg::CMD_RESP, 1'($urandom_range(1))));
        stim_q.push_back(mk_event(aki_pkg::CMD_EXPIRY, 1'b0));
      end else begin
        stim_q.push_back(mk_event(aki_pkg::CMD_EXPIRY, 1'b0));
      end
    end
    if ($urandom_range(9) != 0)
      stim_q.push_back(mk_event(aki_pkg::CMD_END, 1'($urandom_range(1))));
  endtask

  // Offers one event, with a random gap first, and waits for its transaction.
  task automatic send_event(ka_event_t ev);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= ev.op;
    foreground <= ev.fg;
    offer      <= ev;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Sends the queued events, then waits until every result has come back.
  task automatic run_phase(int unsigned src_pct, int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (stim_q.size() != 0)
      send_event(stim_q.pop_front());
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [aki_pkg::INDEX_BITS-1:0] idx, ival_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Writes the whole register map; threshold writes carry junk upper bits.
  task automatic program_regs(ival_t mn, ival_t mx, ival_t st, ival_t mg,
                              thr_t up, thr_t dn, thr_t pr);
    write_reg(REG_UNUSED, $urandom());
    write_reg(aki_pkg::REG_MIN_INTERVAL, mn);
    write_reg(aki_pkg::REG_MAX_INTERVAL, mx);
    write_reg(aki_pkg::REG_STEP_SIZE, st);
    write_reg(aki_pkg::REG_CEILING_MARGIN, mg);
    write_reg(aki_pkg::REG_SUCCESSES_TO_RAISE,
              {(IB-aki_pkg::THRESH_BITS)'($urandom()), up});
    write_reg(aki_pkg::REG_FAILURES_TO_LOWER,
              {(IB-aki_pkg::THRESH_BITS)'($urandom()), dn});
    write_reg(aki_pkg::REG_PROBE_SUCCESSES,
              {(IB-aki_pkg::THRESH_BITS)'($urandom()), pr});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fill_random();
    while (stim_q.size() < PHASE_ITEMS)
      add_session();
  endtask

  // Receiver: random stalls, plus a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Register writes, accepted events and results, all seen at the clock edge.
  always @(posedge clk) begin
    ka_result_t want;
    ka_result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aki_pkg::REG_MIN_INTERVAL:       min_iv      = cfg_data;
          aki_pkg::REG_MAX_INTERVAL:       max_iv      = cfg_data;
          aki_pkg::REG_STEP_SIZE:          step_iv     = cfg_data;
          aki_pkg::REG_CEILING_MARGIN:     margin_iv   = cfg_data;
          aki_pkg::REG_SUCCESSES_TO_RAISE:
            raise_after = cfg_data[aki_pkg::THRESH_BITS-1:0];
          aki_pkg::REG_FAILURES_TO_LOWER:
            lower_after = cfg_data[aki_pkg::THRESH_BITS-1:0];
          aki_pkg::REG_PROBE_SUCCESSES:
            probe_after = cfg_data[aki_pkg::THRESH_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = keepalive_predict(offer.op, offer.fg);
        if (offer.typed)
          want = offer.want;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{next_interval, send_heartbeat, timed_out, is_stable_now};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: next_interval=%0d send=%b timeout=%b stable=%b",
                     got.next, got.send, got.tmo, got.stab);
        end else begin
          want = pending_results.pop_front();
          if (got.next !== want.next || got.send !== want.send ||
              got.tmo !== want.tmo || got.stab !== want.stab) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch (exp/got): next %0d/%0d send %b/%b tmo %b/%b stable %b/%b",
                       want.next, got.next, want.send, got.send,
                       want.tmo, got.tmo, want.stab, got.stab);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    ival_t lo;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset configuration.
    foreach (DIRECTED_EVENTS[i])
      stim_q.push_back(DIRECTED_EVENTS[i]);
    run_phase(10, 67);

    // Small random setting.
    lo = $urandom_range(2000);
    program_regs(lo, lo + $urandom_range(20000), $urandom_range(3000, 1),
                 $urandom_range(5000), thr_t'($urandom_range(4)),
                 thr_t'($urandom_range(4)), thr_t'($urandom_range(3)));
    fill_random();
    run_phase(10, 67);

    // Upper extremes: every raise reaches the maximum, every threshold is zero.
    program_regs('0, '1, '1, '0, '0, '0, '0);
    fill_random();
    run_phase(10, 67);

    // Margin above the maximum, so the ceiling is zero, and a minimum at full scale.
    program_regs('1, '0, '0, '1, '1, '1, '0);
    fill_random();
    run_phase(67, 10);

    // Full-range intervals with a probe count that is never passed.
    program_regs($urandom(), $urandom(), $urandom(), $urandom(),
                 thr_t'($urandom_range(8)), thr_t'($urandom_range(8)), '1);
    fill_random();
    run_phase(67, 10);

    // Large steps near the top of the range, behind a long receiver hold.
    lo = $urandom_range(1000);
    program_regs(lo, 32'hFFFF_FFFF - $urandom_range(1000),
                 32'h8000_0000 + $urandom_range(32'h7FFF_FFFF),
                 $urandom_range(1000), thr_t'($urandom_range(3)),
                 thr_t'($urandom_range(3)), thr_t'($urandom_range(2)));
    hold_req = LONG_HOLD;
    fill_random();
    run_phase(0, 0);

    // Small random setting again, with no idling.
    lo = $urandom_range(100);
    program_regs(lo, lo + $urandom_range(5000), $urandom_range(500, 1),
                 $urandom_range(500), thr_t'($urandom_range(3)),
                 thr_t'($urandom_range(2, 1)), thr_t'($urandom_range(3)));
    fill_random();
    run_phase(0, 0);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/aki_pkg.sv
src/aki_step.sv
src/adaptive_keepalive_interval.sv
tb/sv/adaptive_keepalive_interval_test.sv
